[src/tcc_pkg.sv]
`default_nettype none

package tcc_pkg;

  // operation codes on the func field
  typedef enum logic [1:0] {
    FUNC_PUT   = 2'd0,
    FUNC_SET   = 2'd1,
    FUNC_READ  = 2'd2,
    FUNC_CLEAR = 2'd3
  } func_e;

  // control characters handled by put
  localparam logic [7:0] CH_BACKSPACE = 8'd8;
  localparam logic [7:0] CH_TAB       = 8'd9;
  localparam logic [7:0] CH_NEWLINE   = 8'd10;

  // attribute of every cell after reset
  localparam logic [7:0] RESET_ATTR = 8'h0F;

  // microprogram step labels
  typedef enum logic [3:0] {
    U_IDLE   = 4'd0,
    U_RST    = 4'd1,
    U_PUT    = 4'd2,
    U_CHAR   = 4'd3,
    U_SCOPY  = 4'd4,
    U_SDRAIN = 4'd5,
    U_SBLANK = 4'd6,
    U_SFIX   = 4'd7,
    U_SET    = 4'd8,
    U_RD0    = 4'd9,
    U_RD1    = 4'd10,
    U_CLR    = 4'd11,
    U_CLRFIN = 4'd12,
    U_OUT    = 4'd13
  } upc_e;

  // sequencing of a step
  typedef enum logic [2:0] {
    SEQ_DISPATCH, // wait for an item, branch on func
    SEQ_JUMP,     // go to target
    SEQ_LOOP,     // stay until cond, then go to target
    SEQ_BR,       // cond ? target : next step
    SEQ_OUT       // wait for the result register, then go to target
  } seq_e;

  typedef enum logic [1:0] {
    COND_NONE,
    COND_LAST_ALL,
    COND_LAST_COPY,
    COND_PAST_END
  } cond_e;

  // cell store write source
  typedef enum logic [1:0] {
    WR_NONE,
    WR_RESET_BLANK,
    WR_BLANK
  } wr_e;

  // cell store read source
  typedef enum logic [1:0] {
    RD_NONE,
    RD_COPY,
    RD_CELL
  } rd_e;

  typedef enum logic [1:0] {
    ADDR_HOLD,
    ADDR_INC,
    ADDR_ZERO
  } addr_e;

  // cursor unit operation
  typedef enum logic [2:0] {
    CUR_NONE,
    CUR_CHAR,
    CUR_SET,
    CUR_HOME,
    CUR_SCROLL
  } cur_e;

  // one control word of the microprogram
  typedef struct packed {
    seq_e  seq;
    cond_e cond;
    upc_e  target;
    wr_e   wr;
    rd_e   rd;
    addr_e addr_op;
    cur_e  cur;
    logic  ld_cell;
  } ucw_t;

  // sequencer to datapath
  typedef struct packed {
    logic  accept;
    logic  out_load;
    wr_e   wr;
    rd_e   rd;
    addr_e addr_op;
    cur_e  cur;
    logic  ld_cell;
  } ctl_t;

  // datapath to sequencer
  typedef struct packed {
    logic last_all;
    logic last_copy;
    logic past_end;
    logic out_free;
  } stat_t;

endpackage

`default_nettype wire

[src/text_console_cursor_engine.sv]
`default_nettype none

// Text console engine with a ROWS x COLUMNS cell store (char in the low byte,
// attribute in the high byte) and a cursor. Each item (put char, set cursor,
// read cell, clear screen) gives exactly one result item. A short microprogram
// steps a single-port-write, registered-read cell memory. A put that starts
// past the last cell scrolls first: each cell below the top row is copied one
// row up, then the bottom row is blanked. Clear screen blanks every cell and
// homes the cursor. After reset the store is cleared one cell a cycle, during
// which input items stall; attribute writes are taken at any time. The result
// register lets the next item enter while a result waits.
module text_console_cursor_engine
  import tcc_pkg::*;
#(
  parameter int COLUMNS   = 80,
  parameter int ROWS      = 25,
  parameter int TAB_CELLS = 8
) (
  input  wire         clk_i,
  input  wire         rst_ni,
  input  wire         in_valid_i,
  output logic        in_stall_o,
  input  wire  [1:0]  func_i,
  input  wire  [7:0]  char_code_i,
  input  wire  [4:0]  row_i,
  input  wire  [6:0]  column_i,
  input  wire         cfg_we_i,
  input  wire  [7:0]  cfg_wdata_i,
  output logic        out_valid_o,
  input  wire         out_stall_i,
  output logic [10:0] cursor_pos_o,
  output logic [7:0]  cell_char_o,
  output logic [7:0]  cell_attr_o,
  output logic        scrolled_o
);

  ctl_t  ctl;
  stat_t stat;

  // microprogram sequencer
  tcc_sequencer u_seq (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .func_i     (func_i),
    .stat_i     (stat),
    .ctl_o      (ctl),
    .in_stall_o (in_stall_o)
  );

  // cell store, cursor unit and result register
  tcc_datapath #(
    .COLUMNS   (COLUMNS),
    .ROWS      (ROWS),
    .TAB_CELLS (TAB_CELLS)
  ) u_dp (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .ctl_i        (ctl),
    .stat_o       (stat),
    .char_code_i  (char_code_i),
    .row_i        (row_i),
    .column_i     (column_i),
    .cfg_we_i     (cfg_we_i),
    .cfg_wdata_i  (cfg_wdata_i),
    .out_stall_i  (out_stall_i),
    .out_valid_o  (out_valid_o),
    .cursor_pos_o (cursor_pos_o),
    .cell_char_o  (cell_char_o),
    .cell_attr_o  (cell_attr_o),
    .scrolled_o   (scrolled_o)
  );

endmodule

`default_nettype wire

[src/tcc_sequencer.sv]
`default_nettype none

module tcc_sequencer
  import tcc_pkg::*;
(
  input  wire        clk_i,
  input  wire        rst_ni,
  input  wire        in_valid_i,
  input  wire  [1:0] func_i,
  input  stat_t      stat_i,
  output ctl_t       ctl_o,
  output logic       in_stall_o
);

  localparam ucw_t UCW_NOP = '{
    seq: SEQ_JUMP, cond: COND_NONE, target: U_IDLE, wr: WR_NONE, rd: RD_NONE,
    addr_op: ADDR_HOLD, cur: CUR_NONE, ld_cell: 1'b0
  };

  // microprogram rom
  function automatic ucw_t ucode_rom(input upc_e a);
    ucw_t w;
    w = UCW_NOP;
    case (a)
      U_IDLE: begin
        w.seq     = SEQ_DISPATCH;
        w.addr_op = ADDR_ZERO;
      end
      U_RST: begin
        w.seq     = SEQ_LOOP;
        w.cond    = COND_LAST_ALL;
        w.target  = U_IDLE;
        w.wr      = WR_RESET_BLANK;
        w.addr_op = ADDR_INC;
      end
      U_PUT: begin
        w.seq    = SEQ_BR;
        w.cond   = COND_PAST_END;
        w.target = U_SCOPY;
      end
      U_CHAR: begin
        w.target = U_OUT;
        w.cur    = CUR_CHAR;
      end
      U_SCOPY: begin
        w.seq     = SEQ_LOOP;
        w.cond    = COND_LAST_COPY;
        w.target  = U_SDRAIN;
        w.rd      = RD_COPY;
        w.addr_op = ADDR_INC;
      end
      U_SDRAIN: begin
        w.target = U_SBLANK;
      end
      U_SBLANK: begin
        w.seq     = SEQ_LOOP;
        w.cond    = COND_LAST_ALL;
        w.target  = U_SFIX;
        w.wr      = WR_BLANK;
        w.addr_op = ADDR_INC;
      end
      U_SFIX: begin
        w.target = U_CHAR;
        w.cur    = CUR_SCROLL;
      end
      U_SET: begin
        w.target = U_OUT;
        w.cur    = CUR_SET;
      end
      U_RD0: begin
        w.target = U_RD1;
        w.rd     = RD_CELL;
      end
      U_RD1: begin
        w.target  = U_OUT;
        w.ld_cell = 1'b1;
      end
      U_CLR: begin
        w.seq     = SEQ_LOOP;
        w.cond    = COND_LAST_ALL;
        w.target  = U_CLRFIN;
        w.wr      = WR_BLANK;
        w.addr_op = ADDR_INC;
      end
      U_CLRFIN: begin
        w.target = U_OUT;
        w.cur    = CUR_HOME;
      end
      U_OUT: begin
        w.seq    = SEQ_OUT;
        w.target = U_IDLE;
      end
      default: w = UCW_NOP;
    endcase
    return w;
  endfunction

  upc_e upc_q, upc_d;
  ucw_t ucw;
  logic cond_ok;

  assign ucw = ucode_rom(upc_q);

  // condition select
  always_comb begin
    case (ucw.cond)
      COND_LAST_ALL:  cond_ok = stat_i.last_all;
      COND_LAST_COPY: cond_ok = stat_i.last_copy;
      COND_PAST_END:  cond_ok = stat_i.past_end;
      default:        cond_ok = 1'b0;
    endcase
  end

  // next step and control word
  always_comb begin
    upc_d          = upc_q;
    ctl_o.accept   = 1'b0;
    ctl_o.out_load = 1'b0;
    ctl_o.wr       = ucw.wr;
    ctl_o.rd       = ucw.rd;
    ctl_o.addr_op  = ucw.addr_op;
    ctl_o.cur      = ucw.cur;
    ctl_o.ld_cell  = ucw.ld_cell;
    case (ucw.seq)
      SEQ_DISPATCH: begin
        if (in_valid_i) begin
          ctl_o.accept = 1'b1;
          case (func_i)
            FUNC_PUT:  upc_d = U_PUT;
            FUNC_SET:  upc_d = U_SET;
            FUNC_READ: upc_d = U_RD0;
            default:   upc_d = U_CLR;
          endcase
        end
      end
      SEQ_JUMP: upc_d = ucw.target;
      SEQ_LOOP: begin
        if (cond_ok) upc_d = ucw.target;
      end
      SEQ_BR: begin
        upc_d = cond_ok ? ucw.target : upc_e'(upc_q + 4'd1);
      end
      SEQ_OUT: begin
        if (stat_i.out_free) begin
          ctl_o.out_load = 1'b1;
          upc_d          = ucw.target;
        end
      end
      default: upc_d = U_IDLE;
    endcase
  end

  // step counter, reset runs the store clearing pass
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      upc_q <= U_RST;
    end else begin
      upc_q <= upc_d;
    end
  end

  assign in_stall_o = (upc_q != U_IDLE);

endmodule

`default_nettype wire

[src/tcc_datapath.sv]
`default_nettype none

module tcc_datapath
  import tcc_pkg::*;
#(
  parameter int COLUMNS   = 80,
  parameter int ROWS      = 25,
  parameter int TAB_CELLS = 8
) (
  input  wire         clk_i,
  input  wire         rst_ni,
  input  ctl_t        ctl_i,
  output stat_t       stat_o,
  input  wire  [7:0]  char_code_i,
  input  wire  [4:0]  row_i,
  input  wire  [6:0]  column_i,
  input  wire         cfg_we_i,
  input  wire  [7:0]  cfg_wdata_i,
  input  wire         out_stall_i,
  output logic        out_valid_o,
  output logic [10:0] cursor_pos_o,
  output logic [7:0]  cell_char_o,
  output logic [7:0]  cell_attr_o,
  output logic        scrolled_o
);

  localparam int CELLS   = ROWS * COLUMNS;
  localparam int CW      = $clog2(CELLS + 1);
  localparam int AW      = $clog2(CELLS);
  localparam int COLW    = $clog2(COLUMNS);
  localparam int RW      = $clog2(ROWS + 1);
  localparam int TW      = $clog2(TAB_CELLS);
  localparam int RT      = 1 << RW;
  localparam int END_TAB = CELLS % TAB_CELLS;
  localparam int SCR_TAB = (CELLS - COLUMNS) % TAB_CELLS;

  // cursor position modulo the tab width, per row start and per column
  logic [TW-1:0] row_mod [RT];
  logic [TW-1:0] col_mod [128];

  for (genvar g = 0; g < RT; g++) begin : g_row_mod
    assign row_mod[g] = TW'((g * COLUMNS) % TAB_CELLS);
  end
  for (genvar g = 0; g < 128; g++) begin : g_col_mod
    assign col_mod[g] = TW'(g % TAB_CELLS);
  end

  logic [7:0]    attr_q;
  logic [AW-1:0] addr_q, addr_d;
  logic [CW-1:0] cursor_q, cursor_d;
  logic [COLW-1:0] col_q, col_d;
  logic [RW-1:0] row_q, row_d;
  logic [TW-1:0] tab_q, tab_d;
  logic [7:0]    ch_q;
  logic [4:0]    row_in_q;
  logic [6:0]    col_in_q;
  logic [CW-1:0] pos_q;
  logic          rng_q;
  logic          scrolled_q;
  logic [15:0]   cell_q;
  logic [15:0]   rdata_q;
  logic          wv_q;
  logic [AW-1:0] wa_q;
  logic          out_valid_q;
  logic [10:0]   out_cursor_q;
  logic [15:0]   out_cell_q;
  logic          out_scrolled_q;
  logic [15:0]   mem [CELLS];

  // configuration register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      attr_q <= RESET_ATTR;
    end else if (cfg_we_i) begin
      attr_q <= cfg_wdata_i;
    end
  end

  // item capture
  always_ff @(posedge clk_i) begin
    if (ctl_i.accept) begin
      ch_q     <= char_code_i;
      row_in_q <= row_i;
      col_in_q <= column_i;
      pos_q    <= CW'(32'(row_i) * COLUMNS + 32'(column_i));
      rng_q    <= (32'(row_i) < ROWS) && (32'(column_i) < COLUMNS);
    end
  end

  // character classes
  logic is_nl, is_tab, is_bs, is_print;
  assign is_nl    = (ch_q == CH_NEWLINE);
  assign is_tab   = (ch_q == CH_TAB);
  assign is_bs    = (ch_q == CH_BACKSPACE);
  assign is_print = !is_nl && !is_tab && !is_bs;

  // cursor arithmetic
  logic [COLW:0]   col_left;
  logic [CW-1:0]   nl_cursor;
  logic [RW-1:0]   row_inc;
  logic [TW:0]     tab_gap;
  logic [CW:0]     tab_sum;
  logic            tab_sat;
  logic [COLW:0]   tab_col;
  logic            tab_wrap;
  logic [COLW:0]   tab_col_w;
  logic [COLW:0]   col_inc;
  logic [TW:0]     tab_inc;
  logic [TW:0]     set_tab;
  logic [TW:0]     set_tab_w;
  logic [CW-1:0]   cursor_dec;

  assign col_left   = (COLW + 1)'(COLUMNS) - {1'b0, col_q};
  assign nl_cursor  = cursor_q + CW'(col_left);
  assign row_inc    = row_q + 1'b1;
  assign tab_gap    = (TW + 1)'(TAB_CELLS) - {1'b0, tab_q};
  assign tab_sum    = {1'b0, cursor_q} + (CW + 1)'(tab_gap);
  assign tab_sat    = tab_sum > (CW + 1)'(CELLS);
  assign tab_col    = {1'b0, col_q} + (COLW + 1)'(tab_gap);
  assign tab_wrap   = tab_col >= (COLW + 1)'(COLUMNS);
  assign tab_col_w  = tab_col - (COLW + 1)'(COLUMNS);
  assign col_inc    = {1'b0, col_q} + 1'b1;
  assign tab_inc    = {1'b0, tab_q} + 1'b1;
  assign set_tab    = {1'b0, row_mod[RW'(row_in_q)]} + {1'b0, col_mod[col_in_q]};
  assign set_tab_w  = set_tab - (TW + 1)'(TAB_CELLS);
  assign cursor_dec = cursor_q - 1'b1;

  // cursor unit
  always_comb begin
    cursor_d = cursor_q;
    col_d    = col_q;
    row_d    = row_q;
    tab_d    = tab_q;
    case (ctl_i.cur)
      CUR_CHAR: begin
        if (is_nl) begin
          cursor_d = nl_cursor;
          col_d    = '0;
          row_d    = row_inc;
          tab_d    = row_mod[row_inc];
        end else if (is_tab) begin
          if (tab_sat) begin
            cursor_d = CW'(CELLS);
            col_d    = '0;
            row_d    = RW'(ROWS);
            tab_d    = TW'(END_TAB);
          end else begin
            cursor_d = tab_sum[CW-1:0];
            tab_d    = '0;
            if (tab_wrap) begin
              col_d = tab_col_w[COLW-1:0];
              row_d = row_inc;
            end else begin
              col_d = tab_col[COLW-1:0];
            end
          end
        end else if (is_bs) begin
          if (cursor_q != '0) begin
            cursor_d = cursor_dec;
            if (col_q == '0) begin
              col_d = COLW'(COLUMNS - 1);
              row_d = row_q - 1'b1;
            end else begin
              col_d = col_q - 1'b1;
            end
            tab_d = (tab_q == '0) ? TW'(TAB_CELLS - 1) : tab_q - 1'b1;
          end
        end else begin
          cursor_d = cursor_q + 1'b1;
          if (col_inc == (COLW + 1)'(COLUMNS)) begin
            col_d = '0;
            row_d = row_inc;
          end else begin
            col_d = col_inc[COLW-1:0];
          end
          tab_d = (tab_inc == (TW + 1)'(TAB_CELLS)) ? '0 : tab_inc[TW-1:0];
        end
      end
      CUR_SET: begin
        if (rng_q) begin
          cursor_d = pos_q;
          col_d    = COLW'(col_in_q);
          row_d    = RW'(row_in_q);
          tab_d    = (set_tab >= (TW + 1)'(TAB_CELLS)) ? set_tab_w[TW-1:0]
                                                       : set_tab[TW-1:0];
        end
      end
      CUR_HOME: begin
        cursor_d = '0;
        col_d    = '0;
        row_d    = '0;
        tab_d    = '0;
      end
      CUR_SCROLL: begin
        cursor_d = CW'(CELLS - COLUMNS);
        col_d    = '0;
        row_d    = RW'(ROWS - 1);
        tab_d    = TW'(SCR_TAB);
      end
      default: ;
    endcase
  end

  // sweep address
  always_comb begin
    case (ctl_i.addr_op)
      ADDR_INC:  addr_d = addr_q + 1'b1;
      ADDR_ZERO: addr_d = '0;
      default:   addr_d = addr_q;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      addr_q   <= '0;
      cursor_q <= '0;
      col_q    <= '0;
      row_q    <= '0;
      tab_q    <= '0;
      wv_q     <= 1'b0;
    end else begin
      addr_q   <= addr_d;
      cursor_q <= cursor_d;
      col_q    <= col_d;
      row_q    <= row_d;
      tab_q    <= tab_d;
      wv_q     <= (ctl_i.rd == RD_COPY);
    end
  end

  // scroll copy is written in the cycle after its read
  always_ff @(posedge clk_i) begin
    wa_q <= addr_q;
  end

  // cell store write port
  logic          mem_we;
  logic [AW-1:0] mem_wa;
  logic [15:0]   mem_wd;

  always_comb begin
    mem_we = 1'b0;
    mem_wa = addr_q;
    mem_wd = {attr_q, 8'h00};
    if (wv_q) begin
      mem_we = 1'b1;
      mem_wa = wa_q;
      mem_wd = rdata_q;
    end else if (ctl_i.cur == CUR_CHAR) begin
      if (is_bs && cursor_q != '0) begin
        mem_we = 1'b1;
        mem_wa = AW'(cursor_dec);
      end else if (is_print) begin
        mem_we = 1'b1;
        mem_wa = AW'(cursor_q);
        mem_wd = {attr_q, ch_q};
      end
    end else begin
      case (ctl_i.wr)
        WR_RESET_BLANK: begin
          mem_we = 1'b1;
          mem_wd = {RESET_ATTR, 8'h00};
        end
        WR_BLANK: mem_we = 1'b1;
        default: ;
      endcase
    end
  end

  // cell store read port
  logic          rd_en;
  logic [AW-1:0] rd_addr;
  assign rd_en   = (ctl_i.rd != RD_NONE);
  assign rd_addr = (ctl_i.rd == RD_COPY) ? addr_q + AW'(COLUMNS) : AW'(pos_q);

  always_ff @(posedge clk_i) begin
    if (mem_we) mem[mem_wa] <= mem_wd;
    if (rd_en) rdata_q <= mem[rd_addr];
  end

  // per-item result flags
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      scrolled_q <= 1'b0;
      cell_q     <= '0;
    end else if (ctl_i.accept) begin
      scrolled_q <= 1'b0;
      cell_q     <= '0;
    end else begin
      if (ctl_i.cur == CUR_SCROLL) scrolled_q <= 1'b1;
      if (ctl_i.ld_cell && rng_q) cell_q <= rdata_q;
    end
  end

  // result register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (ctl_i.out_load) begin
      out_valid_q <= 1'b1;
    end else if (!out_stall_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ctl_i.out_load) begin
      out_cursor_q   <= 11'(cursor_q);
      out_cell_q     <= cell_q;
      out_scrolled_q <= scrolled_q;
    end
  end

  assign out_valid_o  = out_valid_q;
  assign cursor_pos_o = out_cursor_q;
  assign cell_char_o  = out_cell_q[7:0];
  assign cell_attr_o  = out_cell_q[15:8];
  assign scrolled_o   = out_scrolled_q;

  // status to the sequencer
  assign stat_o.last_all  = (addr_q == AW'(CELLS - 1));
  assign stat_o.last_copy = (addr_q == AW'(CELLS - COLUMNS - 1));
  assign stat_o.past_end  = (cursor_q == CW'(CELLS));
  assign stat_o.out_free  = !out_valid_q || !out_stall_i;

  // cursor index agrees with its row and column
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (32'(row_q) * COLUMNS + 32'(col_q)) == 32'(cursor_q))
    else $error("cursor index out of step with row and column");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    32'(cursor_q) <= CELLS && 32'(col_q) < COLUMNS && 32'(tab_q) < TAB_CELLS)
    else $error("cursor state out of range");

  // a pending scroll copy never meets another store write
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    wv_q |-> (ctl_i.wr == WR_NONE && ctl_i.cur != CUR_CHAR))
    else $error("store write collides with scroll copy");

  // a result is loaded only into a free output register
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    ctl_i.out_load |-> (!out_valid_q || !out_stall_i))
    else $error("result overwritten while stalled");

endmodule

`default_nettype wire
